[rtl/linear_assignment_solver_macros.svh]
// ----------------------------------------------------------------------------
// linear assignment solver assertion macros
// shared property shorthands for the solver rtl
// ----------------------------------------------------------------------------
`ifndef LINEAR_ASSIGNMENT_SOLVER_MACROS_SVH
`define LINEAR_ASSIGNMENT_SOLVER_MACROS_SVH

// same-cycle implication, reset masked
`define LAS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define LAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/las_pkg.sv]
// ----------------------------------------------------------------------------
// las_pkg
// widths, register indexes and fixed constants of the assignment solver
// ----------------------------------------------------------------------------
package las_pkg;

    localparam int IDX_W  = 6;
    localparam int COST_W = 32;
    localparam int POT_W  = 64;
    localparam int SIZE_W = 7;
    localparam int PAD_W  = 40;
    localparam int REG_W  = 2;

    // register indexes
    localparam logic [REG_W-1:0] REG_ROWS = 2'd0;
    localparam logic [REG_W-1:0] REG_COLS = 2'd1;
    localparam logic [REG_W-1:0] REG_PAD  = 2'd2;

    localparam logic [PAD_W-1:0] PAD_RESET = 40'd655360000000;

    // 1e12 in Q16.16
    localparam logic signed [POT_W-1:0] SLACK_INF = 64'sd65536000000000000;

endpackage

[rtl/las_if.sv]
// ----------------------------------------------------------------------------
// las interfaces
// entry, pair and register-write channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface las_entry_if import las_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         entry_row;
    logic [IDX_W-1:0]         entry_col;
    logic signed [COST_W-1:0] cost_value;
    logic                     last_entry;

    modport source (output valid, entry_row, entry_col, cost_value, last_entry,
                    input ready);
    modport sink   (input valid, entry_row, entry_col, cost_value, last_entry,
                    output ready);
endinterface

interface las_pair_if import las_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] pair_row;
    logic [IDX_W-1:0] pair_col;
    logic             last_pair;
    logic             no_pair;

    modport source (output valid, pair_row, pair_col, last_pair, no_pair, input ready);
    modport sink   (input valid, pair_row, pair_col, last_pair, no_pair, output ready);
endinterface

interface las_cfg_if import las_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REG_W-1:0] index;
    logic [PAD_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/las_ram.sv]
// ----------------------------------------------------------------------------
// las_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module las_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/linear_assignment_solver.sv]
// ----------------------------------------------------------------------------
// linear_assignment_solver
// minimum-cost assignment by the dual-potential hungarian method
// ----------------------------------------------------------------------------
// usage: write rows_in_use, cols_in_use and pad_cost on cfg while idle. load
// cost words on entry, one per cycle; the word with last_entry set is stored
// and starts the solve, and entry.ready stays low until the last pair leaves.
// results leave on pair: min(n,m) words ordered by the shorter side, the last
// one flagged by last_pair; a zero size gives a single no_pair word.
// passes: s = max(n,m). a clearing pass starts every solve, then for each
// of s rows an init pass and a series of search steps, each a scan pass
// plus a potential update pass over the column memory, each one column a
// cycle through a four-stage read-modify-write pipe, then a walk back along
// the augmenting links; an inverse pass and a read, load and hold per pair
// follow. the single column memory port is the bottleneck of the solve.
// reset clears control and restores the register defaults; stored costs are
// not cleared. a stalled pair output holds the solver until taken.
// ----------------------------------------------------------------------------
`include "linear_assignment_solver_macros.svh"

module linear_assignment_solver import las_pkg::*; #(
    parameter int MAX_SIDE = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    las_cfg_if.sink    cfg,
    las_entry_if.sink  entry,
    las_pair_if.source pair
);

    localparam int IW         = $clog2(MAX_SIDE + 1);
    localparam int GW         = $clog2(MAX_SIDE + 2);
    localparam int CDEPTH     = MAX_SIDE * MAX_SIDE;
    localparam int CAW        = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int SIDE_LIMIT = (MAX_SIDE < 64) ? MAX_SIDE : 64;
    localparam logic [CAW-1:0]    SIDE_C = CAW'(MAX_SIDE);
    localparam logic [SIZE_W-1:0] LIMIT7 = SIZE_W'(SIDE_LIMIT);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ZERO     = 4'd1;
    localparam logic [3:0] S_ROW_INIT = 4'd2;
    localparam logic [3:0] S_IT_RD    = 4'd3;
    localparam logic [3:0] S_IT_WT    = 4'd4;
    localparam logic [3:0] S_IT_U     = 4'd5;
    localparam logic [3:0] S_SCAN     = 4'd6;
    localparam logic [3:0] S_UPD      = 4'd7;
    localparam logic [3:0] S_AUG      = 4'd8;
    localparam logic [3:0] S_AUG_LK   = 4'd9;
    localparam logic [3:0] S_AUG_WR   = 4'd10;
    localparam logic [3:0] S_INV      = 4'd11;
    localparam logic [3:0] S_OUT_RD   = 4'd12;
    localparam logic [3:0] S_OUT_LD   = 4'd13;
    localparam logic [3:0] S_OUT_HOLD = 4'd14;
    localparam logic [3:0] S_NOPAIR   = 4'd15;

    typedef struct packed {
        logic signed [POT_W-1:0] v;
        logic signed [POT_W-1:0] ms;
        logic [IW-1:0]           link;
        logic [IW-1:0]           owner;
        logic                    vis;
    } col_ent_t;

    localparam int CEW = $bits(col_ent_t);

    // configuration
    logic [SIZE_W-1:0] rows_reg, cols_reg;
    logic [PAD_W-1:0]  pad_reg;

    // control
    logic [3:0]    state_reg;
    logic          swapped_reg;
    logic [IW-1:0] sq_reg, real_reg, i_reg, k_reg, j0_reg, j1_reg, r0_reg;
    logic [IW-1:0] first_free_reg, own_j1_reg;
    logic [GW-1:0] guard_reg;
    logic          found_reg, padrow_reg;
    logic signed [POT_W-1:0] delta_reg, u_r0_reg;

    // column sweep pipe
    logic          iss_on_reg;
    logic [IW-1:0] iss_j_reg;
    logic          p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    logic [IW-1:0] p1_j_reg, p2_j_reg, p3_j_reg, p4_j_reg;
    col_ent_t      p2_ent_reg, p3_ent_reg, aug_ent_reg;
    logic signed [POT_W-1:0] p2_uv_reg, p2_cell_reg, p3_cur_reg, p4_ms_reg;
    logic          p4_live_reg, p2_uw_reg;
    logic [IW-1:0] p2_o_reg;

    // output word
    logic             pv_reg, plast_reg, pnone_reg;
    logic [IDX_W-1:0] prow_reg, pcol_reg;

    // memories
    logic            cost_we;
    logic [CAW-1:0]  cost_waddr, cost_raddr;
    logic [COST_W-1:0] cost_wdata, cost_rdata;
    logic            col_we;
    logic [IW-1:0]   col_waddr, col_raddr;
    col_ent_t        col_wdata, col_rdata;
    logic            row_we;
    logic [IW-1:0]   row_waddr, row_raddr;
    logic [POT_W-1:0] row_wdata, row_rdata;
    logic            inv_we;
    logic [IW-1:0]   inv_waddr, inv_raddr, inv_wdata, inv_rdata;

    logic          entry_acc, done_w;
    logic [IW-1:0] r0_w, link_w, n_w, m_w;
    logic [CAW-1:0] cr_w, cc_w;
    col_ent_t      scan_ent, upd_ent, init_ent, zero_ent;

    las_ram #(.WIDTH(COST_W), .DEPTH(CDEPTH)) u_cost_ram (
        .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
        .raddr(cost_raddr), .rdata(cost_rdata)
    );

    las_ram #(.WIDTH(CEW), .DEPTH(MAX_SIDE + 1)) u_col_ram (
        .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
        .raddr(col_raddr), .rdata(col_rdata)
    );

    las_ram #(.WIDTH(POT_W), .DEPTH(MAX_SIDE + 1)) u_row_ram (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rdata)
    );

    las_ram #(.WIDTH(IW), .DEPTH(MAX_SIDE + 1)) u_inv_ram (
        .clk(clk), .we(inv_we), .waddr(inv_waddr), .wdata(inv_wdata),
        .raddr(inv_raddr), .rdata(inv_rdata)
    );

    assign cfg.ready   = 1'b1;
    assign entry.ready = (state_reg == S_IDLE);
    assign entry_acc   = entry.valid && entry.ready;

    assign pair.valid     = pv_reg;
    assign pair.pair_row  = prow_reg;
    assign pair.pair_col  = pcol_reg;
    assign pair.last_pair = plast_reg;
    assign pair.no_pair   = pnone_reg;

    assign n_w = (rows_reg > LIMIT7) ? IW'(SIDE_LIMIT) : IW'(rows_reg);
    assign m_w = (cols_reg > LIMIT7) ? IW'(SIDE_LIMIT) : IW'(cols_reg);

    assign done_w = !iss_on_reg && !p1_v_reg && !p2_v_reg && !p3_v_reg && !p4_v_reg;

    // owner of the entered column, clamped into 1..s
    assign r0_w = (col_rdata.owner == '0 || col_rdata.owner > sq_reg)
                  ? IW'(1) : col_rdata.owner;
    assign link_w = (col_rdata.link > sq_reg) ? '0 : col_rdata.link;

    // cost cell of square (r0-1, j-1), transposed when swapped
    assign cr_w = swapped_reg ? CAW'(iss_j_reg - 1'b1) : CAW'(r0_reg - 1'b1);
    assign cc_w = swapped_reg ? CAW'(r0_reg - 1'b1) : CAW'(iss_j_reg - 1'b1);

    always_comb
    begin
        zero_ent = '{v: '0, ms: SLACK_INF, link: '0, owner: '0, vis: 1'b0};

        init_ent     = col_rdata;
        init_ent.ms  = SLACK_INF;
        init_ent.vis = 1'b0;
        if (p1_j_reg == '0)
        begin
            init_ent.owner = i_reg;
        end

        scan_ent = p3_ent_reg;
        if (!p3_ent_reg.vis && (p3_cur_reg < p3_ent_reg.ms))
        begin
            scan_ent.ms   = p3_cur_reg;
            scan_ent.link = j0_reg;
        end

        upd_ent = col_rdata;
        if (col_rdata.vis)
        begin
            upd_ent.v = col_rdata.v - delta_reg;
        end
        else
        begin
            upd_ent.ms = col_rdata.ms - delta_reg;
        end
    end

    always_comb
    begin
        cost_we    = entry_acc && (32'(entry.entry_row) < MAX_SIDE)
                     && (32'(entry.entry_col) < MAX_SIDE);
        cost_waddr = CAW'(entry.entry_row) * SIDE_C + CAW'(entry.entry_col);
        cost_wdata = entry.cost_value;
        cost_raddr = cr_w * SIDE_C + cc_w;

        col_we    = 1'b0;
        col_waddr = iss_j_reg;
        col_wdata = zero_ent;
        col_raddr = iss_j_reg;
        row_we    = 1'b0;
        row_waddr = iss_j_reg;
        row_wdata = '0;
        row_raddr = r0_w;
        inv_we    = 1'b0;
        inv_waddr = col_rdata.owner;
        inv_wdata = p1_j_reg;
        inv_raddr = k_reg;

        case (state_reg)
            S_ZERO:
            begin
                col_we = iss_on_reg;
                row_we = iss_on_reg;
            end
            S_ROW_INIT:
            begin
                col_we    = p1_v_reg;
                col_waddr = p1_j_reg;
                col_wdata = init_ent;
            end
            S_IT_RD, S_AUG:
            begin
                col_raddr = j0_reg;
            end
            S_IT_WT:
            begin
                col_we        = 1'b1;
                col_waddr     = j0_reg;
                col_wdata     = col_rdata;
                col_wdata.vis = 1'b1;
            end
            S_SCAN:
            begin
                col_we    = p3_v_reg;
                col_waddr = p3_j_reg;
                col_wdata = scan_ent;
            end
            S_UPD:
            begin
                col_we    = p1_v_reg;
                col_waddr = p1_j_reg;
                col_wdata = upd_ent;
                row_raddr = col_rdata.owner;
                row_we    = p2_v_reg && p2_uw_reg;
                row_waddr = p2_o_reg;
                row_wdata = POT_W'($signed(row_rdata) + delta_reg);
            end
            S_AUG_LK:
            begin
                col_raddr = link_w;
            end
            S_AUG_WR:
            begin
                col_we          = 1'b1;
                col_waddr       = j0_reg;
                col_wdata       = aug_ent_reg;
                col_wdata.owner = col_rdata.owner;
            end
            S_INV:
            begin
                inv_we = p1_v_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
            cols_reg <= '0;
            pad_reg  <= PAD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ROWS: rows_reg <= cfg.data[SIZE_W-1:0];
                REG_COLS: cols_reg <= cfg.data[SIZE_W-1:0];
                REG_PAD:  pad_reg  <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // datapath of the sweep pipe
    always_ff @(posedge clk)
    begin
        p2_ent_reg  <= col_rdata;
        p2_uv_reg   <= u_r0_reg + col_rdata.v;
        p2_cell_reg <= padrow_reg ? $signed({{(POT_W-PAD_W){1'b0}}, pad_reg})
                                  : $signed({{(POT_W-COST_W){cost_rdata[COST_W-1]}},
                                             cost_rdata});
        p3_ent_reg  <= p2_ent_reg;
        p3_cur_reg  <= p2_cell_reg - p2_uv_reg;
        p4_ms_reg   <= scan_ent.ms;
        p4_live_reg <= !p3_ent_reg.vis;
        p2_uw_reg   <= col_rdata.vis && (col_rdata.owner <= sq_reg);
        p2_o_reg    <= col_rdata.owner;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            swapped_reg    <= 1'b0;
            sq_reg         <= '0;
            real_reg       <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            j0_reg         <= '0;
            j1_reg         <= '0;
            r0_reg         <= '0;
            first_free_reg <= '0;
            own_j1_reg     <= '0;
            guard_reg      <= '0;
            found_reg      <= 1'b0;
            padrow_reg     <= 1'b0;
            delta_reg      <= '0;
            u_r0_reg       <= '0;
            iss_on_reg     <= 1'b0;
            iss_j_reg      <= '0;
            p1_v_reg       <= 1'b0;
            p2_v_reg       <= 1'b0;
            p3_v_reg       <= 1'b0;
            p4_v_reg       <= 1'b0;
            p1_j_reg       <= '0;
            p2_j_reg       <= '0;
            p3_j_reg       <= '0;
            p4_j_reg       <= '0;
            aug_ent_reg    <= '0;
            pv_reg         <= 1'b0;
            plast_reg      <= 1'b0;
            pnone_reg      <= 1'b0;
            prow_reg       <= '0;
            pcol_reg       <= '0;
        end
        else
        begin
            p1_v_reg <= iss_on_reg;
            p1_j_reg <= iss_j_reg;
            p2_v_reg <= p1_v_reg;
            p2_j_reg <= p1_j_reg;
            p3_v_reg <= p2_v_reg;
            p3_j_reg <= p2_j_reg;
            p4_v_reg <= p3_v_reg;
            p4_j_reg <= p3_j_reg;
            if (iss_on_reg)
            begin
                if (iss_j_reg == sq_reg)
                begin
                    iss_on_reg <= 1'b0;
                end
                else
                begin
                    iss_j_reg <= iss_j_reg + 1'b1;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (entry_acc && entry.last_entry)
                    begin
                        if (n_w == '0 || m_w == '0)
                        begin
                            pv_reg    <= 1'b1;
                            pnone_reg <= 1'b1;
                            plast_reg <= 1'b1;
                            prow_reg  <= '0;
                            pcol_reg  <= '0;
                            state_reg <= S_NOPAIR;
                        end
                        else
                        begin
                            swapped_reg <= n_w > m_w;
                            sq_reg      <= (n_w > m_w) ? n_w : m_w;
                            real_reg    <= (n_w > m_w) ? m_w : n_w;
                            iss_on_reg  <= 1'b1;
                            iss_j_reg   <= '0;
                            state_reg   <= S_ZERO;
                        end
                    end
                end
                S_ZERO:
                begin
                    if (done_w)
                    begin
                        i_reg      <= IW'(1);
                        iss_on_reg <= 1'b1;
                        iss_j_reg  <= '0;
                        state_reg  <= S_ROW_INIT;
                    end
                end
                S_ROW_INIT:
                begin
                    if (done_w)
                    begin
                        j0_reg    <= '0;
                        guard_reg <= '0;
                        state_reg <= S_IT_RD;
                    end
                end
                S_IT_RD:
                begin
                    state_reg <= S_IT_WT;
                end
                S_IT_WT:
                begin
                    r0_reg     <= r0_w;
                    padrow_reg <= (r0_w - 1'b1) >= real_reg;
                    state_reg  <= S_IT_U;
                end
                S_IT_U:
                begin
                    u_r0_reg       <= $signed(row_rdata);
                    delta_reg      <= SLACK_INF;
                    found_reg      <= 1'b0;
                    first_free_reg <= '0;
                    j1_reg         <= '0;
                    iss_on_reg     <= 1'b1;
                    iss_j_reg      <= IW'(1);
                    state_reg      <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (p3_v_reg && !p3_ent_reg.vis && first_free_reg == '0)
                    begin
                        first_free_reg <= p3_j_reg;
                    end
                    // strict less-than keeps the lowest column on ties
                    if (p4_v_reg && p4_live_reg && (p4_ms_reg < delta_reg))
                    begin
                        delta_reg <= p4_ms_reg;
                        j1_reg    <= p4_j_reg;
                        found_reg <= 1'b1;
                    end
                    if (done_w)
                    begin
                        if (!found_reg && first_free_reg == '0)
                        begin
                            guard_reg <= '0;
                            state_reg <= S_AUG;
                        end
                        else
                        begin
                            if (!found_reg)
                            begin
                                j1_reg    <= first_free_reg;
                                delta_reg <= '0;
                            end
                            iss_on_reg <= 1'b1;
                            iss_j_reg  <= '0;
                            state_reg  <= S_UPD;
                        end
                    end
                end
                S_UPD:
                begin
                    if (p1_v_reg && p1_j_reg == j1_reg)
                    begin
                        own_j1_reg <= col_rdata.owner;
                    end
                    if (done_w)
                    begin
                        j0_reg <= j1_reg;
                        if (own_j1_reg == '0 || guard_reg >= GW'(sq_reg))
                        begin
                            guard_reg <= '0;
                            state_reg <= S_AUG;
                        end
                        else
                        begin
                            guard_reg <= guard_reg + 1'b1;
                            state_reg <= S_IT_RD;
                        end
                    end
                end
                S_AUG:
                begin
                    if (j0_reg == '0 || guard_reg > GW'(sq_reg))
                    begin
                        iss_on_reg <= 1'b1;
                        if (i_reg == sq_reg)
                        begin
                            iss_j_reg <= IW'(1);
                            state_reg <= S_INV;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            iss_j_reg <= '0;
                            state_reg <= S_ROW_INIT;
                        end
                    end
                    else
                    begin
                        state_reg <= S_AUG_LK;
                    end
                end
                S_AUG_LK:
                begin
                    aug_ent_reg <= col_rdata;
                    j1_reg      <= link_w;
                    state_reg   <= S_AUG_WR;
                end
                S_AUG_WR:
                begin
                    j0_reg    <= j1_reg;
                    guard_reg <= guard_reg + 1'b1;
                    state_reg <= S_AUG;
                end
                S_INV:
                begin
                    if (done_w)
                    begin
                        k_reg     <= IW'(1);
                        state_reg <= S_OUT_RD;
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_LD;
                end
                S_OUT_LD:
                begin
                    pv_reg    <= 1'b1;
                    pnone_reg <= 1'b0;
                    plast_reg <= k_reg == real_reg;
                    prow_reg  <= swapped_reg ? IDX_W'(inv_rdata - 1'b1)
                                             : IDX_W'(k_reg - 1'b1);
                    pcol_reg  <= swapped_reg ? IDX_W'(k_reg - 1'b1)
                                             : IDX_W'(inv_rdata - 1'b1);
                    state_reg <= S_OUT_HOLD;
                end
                S_OUT_HOLD:
                begin
                    if (pair.ready)
                    begin
                        pv_reg <= 1'b0;
                        if (k_reg == real_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                S_NOPAIR:
                begin
                    if (pair.ready)
                    begin
                        pv_reg    <= 1'b0;
                        pnone_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `LAS_ASSERT_IMPL(a_nopair_is_last, clk, rst_n, pair.valid && pair.no_pair,
        pair.last_pair, "no_pair word without last_pair")
    `LAS_ASSERT_NEXT(a_busy_after_last, clk, rst_n,
        entry.valid && entry.ready && entry.last_entry,
        !entry.ready, "entry channel open during solve")
    `LAS_ASSERT_IMPL(a_pair_in_range, clk, rst_n, pair.valid && !pair.no_pair,
        (SIZE_W'(pair.pair_row) < rows_reg) && (SIZE_W'(pair.pair_col) < cols_reg),
        "pair index outside matrix")

endmodule
